// ----- rtl/coalescing_block_write_cache_macros.svh -----
// assertion macros for the block write cache checker
`ifndef COALESCING_BLOCK_WRITE_CACHE_MACROS_SVH
`define COALESCING_BLOCK_WRITE_CACHE_MACROS_SVH

// checked only outside reset
`define CBWC_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define CBWC_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cbwc_pkg.sv -----
// shared types and constants of the block write cache
`timescale 1ns / 1ps
`default_nettype none

package cbwc_pkg;

  localparam int SLOT_COUNT_DEF    = 8;
  localparam int BLOCK_BYTES_DEF   = 256;
  localparam int BLOCK_ID_BITS_DEF = 16;

  localparam logic [15:0] FLUSH_INTERVAL_RESET = 16'd500;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_STORE_SIZE     = 2'd0,
    REG_FLUSH_INTERVAL = 2'd1,
    REG_CACHE_ENABLE   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] target_block;
    logic [7:0]  byte_index;
    logic [7:0]  data_byte;
    logic [2:0]  slot_select;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] run_start_block;
    logic [3:0]  run_block_count;
    logic [2:0]  run_first_slot;
    logic [7:0]  read_value;
    logic        rejected;
    logic        error_latched;
    logic        busy_led;
    logic [3:0]  cached_blocks;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] store_size_blocks;
    logic [15:0] flush_interval_ticks;
    logic        cache_enable;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    item_t item;
    logic  byte0;
    logic  index_ok;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/coalescing_block_write_cache.sv -----
// top level of the coalescing block write cache
//
//  channel   handshake             payload
//  input     push / full           item   (op, target_block, byte_index, data_byte, slot_select)
//  results   pop / empty           result (kind, run fields, read_value, status, last)
//  config    psel/penable/pwrite   paddr, pwdata, prdata, pready (always high)
//
// an item is taken when the back end is idle; a read waits on the registered memory read,
// byte 0 goes through the tag search and possibly an append; a flush scans the occupied
// slots in the run scan loop, then each result is written into the 4-entry result queue.
// reset is synchronous; no memory clearing is needed
// a full result queue stalls the back end, a 2-entry input queue lets push continue
`timescale 1ns / 1ps
`default_nettype none

module coalescing_block_write_cache #(
  parameter int SLOT_COUNT    = cbwc_pkg::SLOT_COUNT_DEF,
  parameter int BLOCK_BYTES   = cbwc_pkg::BLOCK_BYTES_DEF,
  parameter int BLOCK_ID_BITS = cbwc_pkg::BLOCK_ID_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire cbwc_pkg::item_t   item,
  output logic                   empty,
  input  wire logic              pop,
  output cbwc_pkg::result_t      result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cbwc_pkg::cfg_t cfg;
  cbwc_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_take;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.store_size_blocks    <= 16'd0;
      cfg.flush_interval_ticks <= cbwc_pkg::FLUSH_INTERVAL_RESET;
      cfg.cache_enable         <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        cbwc_pkg::REG_STORE_SIZE:     cfg.store_size_blocks    <= pwdata[15:0];
        cbwc_pkg::REG_FLUSH_INTERVAL: cfg.flush_interval_ticks <= pwdata[15:0];
        cbwc_pkg::REG_CACHE_ENABLE:   cfg.cache_enable         <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cbwc_pkg::REG_STORE_SIZE:     prdata = {16'd0, cfg.store_size_blocks};
      cbwc_pkg::REG_FLUSH_INTERVAL: prdata = {16'd0, cfg.flush_interval_ticks};
      cbwc_pkg::REG_CACHE_ENABLE:   prdata = {31'd0, cfg.cache_enable};
      default:                      prdata = 32'd0;
    endcase
  end

  cbwc_front #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  cbwc_back #(
    .SLOT_COUNT    (SLOT_COUNT),
    .BLOCK_BYTES   (BLOCK_BYTES),
    .BLOCK_ID_BITS (BLOCK_ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

// ----- rtl/cbwc_front.sv -----
// front end: accepts items, classifies them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none

module cbwc_front #(
  parameter int BLOCK_BYTES = cbwc_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire cbwc_pkg::item_t item,
  output logic                cmd_valid,
  output cbwc_pkg::cmd_t      cmd,
  input  wire logic           cmd_take
);

  cbwc_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  cbwc_pkg::cmd_t classified;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    classified.item     = item;
    classified.byte0    = (item.byte_index == 8'd0);
    classified.index_ok = (13'(item.byte_index) < 13'(BLOCK_BYTES));
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= classified;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cbwc_back.sv -----
// back end: slot search, byte store, run coalescing flush and result queue
`timescale 1ns / 1ps
`default_nettype none

module cbwc_back #(
  parameter int SLOT_COUNT    = cbwc_pkg::SLOT_COUNT_DEF,
  parameter int BLOCK_BYTES   = cbwc_pkg::BLOCK_BYTES_DEF,
  parameter int BLOCK_ID_BITS = cbwc_pkg::BLOCK_ID_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cbwc_pkg::cfg_t   cfg,
  input  wire logic             cmd_valid,
  input  wire cbwc_pkg::cmd_t   cmd,
  output logic                  cmd_take,
  output logic                  empty,
  input  wire logic             pop,
  output cbwc_pkg::result_t     result
);

  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int CNW = $clog2(SLOT_COUNT + 1);
  localparam int TW  = BLOCK_ID_BITS;
  localparam int CW  = ((BLOCK_ID_BITS > 16) ? BLOCK_ID_BITS : 16) + 1;
  localparam int AW  = $clog2(SLOT_COUNT * BLOCK_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_APPEND, S_FLUSH, S_SCAN, S_RDWAIT, S_DRAIN
  } state_t;

  typedef struct packed {
    logic [15:0] start;
    logic [3:0]  cnt;
    logic [2:0]  slot;
  } desc_t;

  state_t         state;
  cbwc_pkg::cmd_t cur;
  logic [TW-1:0]  tags [SLOT_COUNT];
  logic [CNW-1:0] occ;
  logic [SW-1:0]  active;
  logic           discard;
  logic [15:0]    idle;
  logic           err;
  logic           led;
  logic           flush_ret;
  logic           rd_ok;

  logic [CNW-1:0] run_i;
  logic [CNW-1:0] run_j;
  logic [CW-1:0]  run_start;
  desc_t          desc [SLOT_COUNT];
  logic [CNW-1:0] ndesc;
  logic [CNW-1:0] dptr;
  logic [1:0]     fin_kind;
  logic [7:0]     fin_val;
  logic           fin_rej;

  logic [7:0]     mem [SLOT_COUNT * BLOCK_BYTES];
  logic [7:0]     rdata;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic [AW-1:0]  mem_raddr;

  cbwc_pkg::result_t ofifo [4];
  logic [1:0]        o_wr;
  logic [1:0]        o_rd;
  logic [2:0]        o_cnt;
  logic              o_push;
  logic              o_pop;
  cbwc_pkg::result_t o_entry;

  logic           hit;
  logic [SW-1:0]  hit_slot;
  logic [CW-1:0]  id_ext;
  logic [CW-1:0]  store_ext;
  logic [15:0]    idle_inc;
  logic [CNW-1:0] run_len;
  logic [CW-1:0]  run_end;
  logic           run_ext;
  logic [SW-1:0]  new_slot;
  logic [CNW-1:0] occ_base;

  function automatic logic [AW-1:0] byte_addr(input logic [SW-1:0] slot,
                                              input logic [7:0] idx);
    byte_addr = AW'(slot) * AW'(BLOCK_BYTES) + AW'(idx);
  endfunction

  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign id_ext    = CW'(cur.item.target_block);
  assign store_ext = CW'(cfg.store_size_blocks);
  assign idle_inc  = (idle == 16'hFFFF) ? idle : idle + 16'd1;
  assign run_len   = run_j - run_i;
  assign run_end   = run_start + CW'(run_len);
  assign run_ext   = (run_j < occ) && (CW'(tags[run_j[SW-1:0]]) == run_end);
  assign occ_base  = (occ >= CNW'(SLOT_COUNT)) ? CNW'(SLOT_COUNT - 1) : occ;
  assign new_slot  = occ_base[SW-1:0];
  assign mem_raddr = byte_addr(cmd.item.slot_select[SW-1:0], cmd.item.byte_index);

  // parallel tag compare over occupied slots, lowest match wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      if (CNW'(k) < occ && CW'(tags[k]) == id_ext) begin
        hit      = 1'b1;
        hit_slot = SW'(k);
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = byte_addr(active, cmd.item.byte_index);
    mem_wdata = cmd.item.data_byte;
    case (state)
      S_IDLE: begin
        mem_we = cmd_valid && cmd.item.op == cbwc_pkg::OP_WRITE && !cmd.byte0 &&
                 !discard && CNW'(active) < occ && cmd.index_ok;
      end
      S_SEARCH: begin
        mem_we    = hit;
        mem_waddr = byte_addr(hit_slot, 8'd0);
        mem_wdata = cur.item.data_byte;
      end
      S_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = byte_addr(new_slot, 8'd0);
        mem_wdata = cur.item.data_byte;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // result queue
  always_comb begin
    o_entry                 = '0;
    o_entry.error_latched   = err;
    o_entry.busy_led        = led;
    o_entry.cached_blocks   = 4'(occ);
    o_entry.last            = (dptr == ndesc);
    if (dptr == ndesc) begin
      o_entry.kind       = fin_kind;
      o_entry.read_value = fin_val;
      o_entry.rejected   = fin_rej;
    end else begin
      o_entry.kind            = cbwc_pkg::KIND_RUN;
      o_entry.run_start_block = desc[dptr[SW-1:0]].start;
      o_entry.run_block_count = desc[dptr[SW-1:0]].cnt;
      o_entry.run_first_slot  = desc[dptr[SW-1:0]].slot;
    end
  end

  assign o_push = (state == S_DRAIN) && (o_cnt != 3'd4);
  assign o_pop  = pop && !empty;
  assign empty  = (o_cnt == 3'd0);
  assign result = ofifo[o_rd];

  always_ff @(posedge clk) begin
    if (o_push) begin
      ofifo[o_wr] <= o_entry;
    end
    if (rst) begin
      o_wr  <= 2'd0;
      o_rd  <= 2'd0;
      o_cnt <= 3'd0;
    end else begin
      if (o_push) begin
        o_wr <= o_wr + 2'd1;
      end
      if (o_pop) begin
        o_rd <= o_rd + 2'd1;
      end
      o_cnt <= o_cnt + 3'(o_push) - 3'(o_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      active    <= '0;
      discard   <= 1'b0;
      idle      <= 16'd0;
      err       <= 1'b0;
      led       <= 1'b0;
      flush_ret <= 1'b0;
      ndesc     <= '0;
      dptr      <= '0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
        tags[k] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur       <= cmd;
            fin_kind  <= cbwc_pkg::KIND_STATUS;
            fin_val   <= 8'd0;
            fin_rej   <= 1'b0;
            ndesc     <= '0;
            dptr      <= '0;
            flush_ret <= 1'b0;
            case (cmd.item.op)
              cbwc_pkg::OP_WRITE: begin
                if (cmd.byte0) begin
                  if (CW'(cmd.item.target_block) >= store_ext) begin
                    err     <= 1'b1;
                    discard <= 1'b1;
                    fin_rej <= 1'b1;
                    state   <= S_DRAIN;
                  end else begin
                    if (!err) begin
                      led <= 1'b1;
                    end
                    state <= S_SEARCH;
                  end
                end else if (discard) begin
                  fin_rej <= 1'b1;
                  state   <= S_DRAIN;
                end else begin
                  if (CNW'(active) < occ && cmd.index_ok) begin
                    idle <= 16'd0;
                  end
                  state <= S_DRAIN;
                end
              end
              cbwc_pkg::OP_TICK: begin
                idle <= idle_inc;
                if (cfg.cache_enable && idle_inc >= cfg.flush_interval_ticks) begin
                  state <= S_FLUSH;
                end else begin
                  state <= S_DRAIN;
                end
              end
              cbwc_pkg::OP_FLUSH: begin
                state <= S_FLUSH;
              end
              default: begin
                rd_ok <= (6'(cmd.item.slot_select) < 6'(SLOT_COUNT)) && cmd.index_ok;
                state <= S_RDWAIT;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          fin_kind <= cbwc_pkg::KIND_READ;
          fin_val  <= rd_ok ? rdata : 8'd0;
          state    <= S_DRAIN;
        end
        S_SEARCH: begin
          if (hit) begin
            active  <= hit_slot;
            discard <= 1'b0;
            idle    <= 16'd0;
            state   <= S_DRAIN;
          end else if (occ >= CNW'(SLOT_COUNT)) begin
            flush_ret <= 1'b1;
            state     <= S_FLUSH;
          end else begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          tags[new_slot] <= TW'(cur.item.target_block);
          occ            <= occ_base + CNW'(1);
          active         <= new_slot;
          discard        <= 1'b0;
          idle           <= 16'd0;
          state          <= S_DRAIN;
        end
        S_FLUSH: begin
          if (cfg.store_size_blocks == 16'd0 || occ == '0) begin
            state <= flush_ret ? S_APPEND : S_DRAIN;
          end else begin
            run_start <= CW'(tags[0]);
            run_i     <= '0;
            run_j     <= CNW'(1);
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (run_ext) begin
            run_j <= run_j + CNW'(1);
          end else begin
            // close the run: out of store sets the error, else queue a descriptor
            if (run_end > store_ext) begin
              err <= 1'b1;
            end else begin
              desc[ndesc[SW-1:0]].start <= 16'(run_start);
              desc[ndesc[SW-1:0]].cnt   <= 4'(run_len);
              desc[ndesc[SW-1:0]].slot  <= 3'(run_i);
              ndesc                     <= ndesc + CNW'(1);
            end
            if (run_j >= occ) begin
              occ <= '0;
              if (!err && !(run_end > store_ext)) begin
                led <= 1'b0;
              end
              state <= flush_ret ? S_APPEND : S_DRAIN;
            end else begin
              run_start <= CW'(tags[run_j[SW-1:0]]);
              run_i     <= run_j;
              run_j     <= run_j + CNW'(1);
            end
          end
        end
        S_DRAIN: begin
          if (o_push) begin
            if (dptr == ndesc) begin
              state <= S_IDLE;
            end else begin
              dptr <= dptr + CNW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cbwc_checker.sv -----
// port-level checks on the result side, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "coalescing_block_write_cache_macros.svh"

module cbwc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              empty,
  input wire logic              pop,
  input wire cbwc_pkg::result_t result
);

  `CBWC_CHECK_ALWAYS(a_empty_after_reset, rst |=> empty, "results pending after reset")
  `CBWC_CHECK(a_read_is_last, (!empty && result.kind == cbwc_pkg::KIND_READ) |-> result.last, "read item result not last")
  `CBWC_CHECK(a_run_shape, (!empty && result.kind == cbwc_pkg::KIND_RUN) |-> (!result.rejected && !result.last && result.run_block_count != 4'd0), "bad run descriptor")
  `CBWC_CHECK(a_result_holds, (!empty && !pop) |=> (!empty && $stable(result)), "stalled result changed")

endmodule

bind coalescing_block_write_cache cbwc_checker u_cbwc_checker (.*);

`default_nettype wire
